@@ hw/rtl/afbr_pkg.sv @@
// ----------------------------------------------------------------------------
// afbr_pkg
// Shared widths, constants, types and constant functions for the flat-bottom
// adaptive restraint force pipeline.
// ----------------------------------------------------------------------------
package afbr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int MIN_TARGET = (ONE + 5) / 10;
    localparam int MIN_WIDTH  = (ONE + 50) / 100;
    localparam int ALPHA_EPS  = (ONE + 9999) / 10000;

    localparam int LEN_W    = 24;
    localparam int KAPPA_W  = 32;
    localparam int FORCE_W  = 40;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int AX_W     = LEN_W;
    localparam int KX_W     = KAPPA_W + AX_W;
    localparam int C2_W     = 2 * LEN_W;
    localparam int AX2_W    = 2 * AX_W;
    localparam int EA_W     = ((FRAC_BITS + 1 > LEN_W - 1) ? FRAC_BITS + 1 : LEN_W - 1) + 1;
    localparam int D_W      = C2_W + EA_W;

    localparam int LOG_W      = 128;
    localparam int LZ_W       = 7;
    localparam int NORM_STEPS = 7;
    localparam int LOG_BITS   = 32;
    localparam int LOG_OUT_W  = LZ_W + LOG_BITS;
    localparam int LOG_LAT    = NORM_STEPS + LOG_BITS;

    localparam int Q_W     = FORCE_W;
    localparam int DEN_W   = C2_W + 2;
    localparam int NUM_W   = KX_W + 1 + FRAC_BITS;
    localparam int DIV_W   = DEN_W + Q_W;
    localparam int DIV_LAT = Q_W + 1;

    localparam int EXP_BITS = 32;
    localparam int EXP_LAT  = EXP_BITS;

    localparam int PROD_W = LOG_OUT_W + EA_W;
    localparam int S_W    = PROD_W + 2;
    localparam int INT_W  = 6;

    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_DISTANCE,
        REG_BAND_HALFWIDTH,
        REG_SPRING_CONSTANT,
        REG_WELL_WIDTH,
        REG_SHAPE_EXPONENT,
        REG_RESTRAINT_ON,
        REG_SHOW_LIMIT,
        REG_MET_LIMIT
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic active;
        logic neg;
        logic azero;
        logic met;
        logic shown;
    } t_meta;

    typedef struct packed {
        logic             zero;
        logic             sat;
        logic [INT_W-1:0] ipart;
    } t_gsh;

    typedef struct packed {
        logic [FORCE_W-1:0] force_value;
        logic               is_met;
        logic               is_shown;
    } t_result;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b_;
        logic [63:0] xv;
        res = '0;
        b_  = 64'd1 << 62;
        xv  = x;
        for (int i = 0; i < 32; i++) begin
            if (b_ > xv) b_ = b_ >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b_ != 0) begin
                if (xv >= res + b_) begin
                    xv  = xv - (res + b_);
                    res = (res >> 1) + b_;
                end else begin
                    res = res >> 1;
                end
                b_ = b_ >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.31, by repeated floor square roots
    function automatic logic [31:0] exp2_root(input int k);
        logic [63:0] s;
        s = 64'd1 << 32;
        for (int j = 1; j <= k; j++) begin
            s = isqrt64(s << 31);
        end
        return s[31:0];
    endfunction

endpackage

@@ hw/rtl/afbr_log2.sv @@
// ----------------------------------------------------------------------------
// afbr_log2
// Pipelined log2 in Q.32: leading-zero normalizer, then one squaring step
// per fraction bit.
// ----------------------------------------------------------------------------
module afbr_log2 (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [afbr_pkg::LOG_W-1:0]       i_value,
    output logic [afbr_pkg::LOG_OUT_W-1:0]   o_log
);

    localparam int W  = afbr_pkg::LOG_W;
    localparam int ZW = afbr_pkg::LZ_W;
    localparam int NS = afbr_pkg::NORM_STEPS;
    localparam int LB = afbr_pkg::LOG_BITS;

    logic [W-1:0]  r_nv [NS];
    logic [ZW-1:0] r_lz [NS];
    logic          r_nz [NS];

    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - j);
        logic [W-1:0]  src;
        logic [ZW-1:0] lz_in;
        logic          nz_in;
        if (j == 0) begin : g_first
            assign src   = i_value;
            assign lz_in = '0;
            assign nz_in = |i_value;
        end else begin : g_next
            assign src   = r_nv[j-1];
            assign lz_in = r_lz[j-1];
            assign nz_in = r_nz[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (src[W-1 -: SH] == '0) begin
                    r_nv[j] <= src << SH;
                    r_lz[j] <= lz_in + ZW'(SH);
                end else begin
                    r_nv[j] <= src;
                    r_lz[j] <= lz_in;
                end
                r_nz[j] <= nz_in;
            end
        end
    end

    logic [LB-1:0] r_y  [LB];
    logic [LB-1:0] r_fb [LB];
    logic [ZW-1:0] r_p  [LB];
    logic          r_z  [LB];

    for (genvar k = 0; k < LB; k++) begin : g_sq
        logic [LB-1:0]   y_in;
        logic [LB-1:0]   fb_in;
        logic [ZW-1:0]   p_in;
        logic            z_in;
        logic [2*LB-1:0] sq;
        if (k == 0) begin : g_first
            assign y_in  = r_nv[NS-1][W-1 -: LB];
            assign fb_in = '0;
            assign p_in  = ZW'(W - 1) - r_lz[NS-1];
            assign z_in  = r_nz[NS-1];
        end else begin : g_next
            assign y_in  = r_y[k-1];
            assign fb_in = r_fb[k-1];
            assign p_in  = r_p[k-1];
            assign z_in  = r_z[k-1];
        end
        assign sq = y_in * y_in;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (sq[2*LB-1]) begin
                    r_y[k]  <= sq[2*LB-1 -: LB];
                    r_fb[k] <= fb_in | (LB'(1) << (LB - 1 - k));
                end else begin
                    r_y[k]  <= sq[2*LB-2 -: LB];
                    r_fb[k] <= fb_in;
                end
                r_p[k] <= p_in;
                r_z[k] <= z_in;
            end
        end
    end

    assign o_log = r_z[LB-1] ? {r_p[LB-1], r_fb[LB-1]} : '0;

endmodule

@@ hw/rtl/afbr_div.sv @@
// ----------------------------------------------------------------------------
// afbr_div
// Pipelined restoring divider, one quotient bit per stage, saturated to the
// force range.
// ----------------------------------------------------------------------------
module afbr_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [afbr_pkg::NUM_W-1:0]     i_num,
    input  logic [afbr_pkg::DEN_W-1:0]     i_den,
    output logic [afbr_pkg::FORCE_W-1:0]   o_quot
);

    localparam int QW = afbr_pkg::Q_W;
    localparam int DW = afbr_pkg::DIV_W;

    logic [DW-1:0]                  r_rem [QW+1];
    logic [afbr_pkg::DEN_W-1:0]     r_den [QW+1];
    logic [QW-1:0]                  r_q   [QW+1];
    logic                           r_sat [QW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_sat[0] <= DW'(i_num) >= (DW'(i_den) << QW);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [DW-1:0] dsh;
        assign dsh = DW'(r_den[k-1]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k-1] >= dsh) begin
                    r_rem[k] <= r_rem[k-1] - dsh;
                    r_q[k]   <= r_q[k-1] | (QW'(1) << B);
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
                r_den[k] <= r_den[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quot = (r_sat[QW] || (r_q[QW] > afbr_pkg::FORCE_MAX)) ?
                    afbr_pkg::FORCE_MAX : r_q[QW];

endmodule

@@ hw/rtl/afbr_exp2.sv @@
// ----------------------------------------------------------------------------
// afbr_exp2
// Pipelined 2^frac in Q1.31: one root-factor multiply per fraction bit.
// ----------------------------------------------------------------------------
module afbr_exp2 (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [afbr_pkg::EXP_BITS-1:0]   i_frac,
    output logic [afbr_pkg::EXP_BITS-1:0]   o_mant
);

    localparam int EB = afbr_pkg::EXP_BITS;

    logic [EB-1:0] r_m  [EB];
    logic [EB-1:0] r_fr [EB];

    for (genvar k = 1; k <= EB; k++) begin : g_stage
        localparam logic [EB-1:0] ROOT = afbr_pkg::exp2_root(k);
        logic [EB-1:0]   m_in;
        logic [EB-1:0]   fr_in;
        logic [2*EB-1:0] prod;
        if (k == 1) begin : g_first
            assign m_in  = EB'(1) << (EB - 1);
            assign fr_in = i_frac;
        end else begin : g_next
            assign m_in  = r_m[k-2];
            assign fr_in = r_fr[k-2];
        end
        assign prod = m_in * ROOT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k-1]  <= fr_in[EB-k] ? prod[EB-1 +: EB] : m_in;
                r_fr[k-1] <= fr_in;
            end
        end
    end

    assign o_mant = r_m[EB-1];

endmodule

@@ hw/rtl/adaptive_flat_bottom_restraint_force_core.sv @@
// ----------------------------------------------------------------------------
// adaptive_flat_bottom_restraint_force_core
// Flat-bottom adaptive robust restraint force, satisfied and display flags.
//
//   channel  direction  handshake                      payload
//   in       input      i_in_valid / o_in_stall        pair_distance, atom shown x2
//   out      output     o_out_valid / i_out_stall      force_value, is_met, is_shown
//   cfg      input      i_cfg_wr_en                    i_cfg_index, i_cfg_wdata
//
// One item per cycle while the skid register is empty. A result reaches the output
// register after the front stages, the four log2 units (39 stages), the shape
// stages and the exp2 unit (32 stages).
// Synchronous active-low reset clears valid bits and sets config registers to their defaults.
// Downstream stall fills a skid register; the whole pipeline holds only while
// that register is full.
// ----------------------------------------------------------------------------
module adaptive_flat_bottom_restraint_force_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [afbr_pkg::LEN_W-1:0]            i_pair_distance,
    input  logic                                  i_first_atom_shown,
    input  logic                                  i_second_atom_shown,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [afbr_pkg::FORCE_W-1:0]   o_force_value,
    output logic                                  o_is_met,
    output logic                                  o_is_shown,
    input  logic                                  i_cfg_wr_en,
    input  logic [afbr_pkg::IDX_W-1:0]            i_cfg_index,
    input  logic [afbr_pkg::CFG_W-1:0]            i_cfg_wdata
);

    localparam int F    = afbr_pkg::FRAC_BITS;
    localparam int LW   = afbr_pkg::LEN_W;
    localparam int EAW  = afbr_pkg::EA_W;
    localparam int FW   = afbr_pkg::FORCE_W;
    localparam int VMW  = LW + F;
    localparam int CMPW = (VMW > afbr_pkg::C2_W) ? VMW : afbr_pkg::C2_W;
    localparam int SW   = afbr_pkg::S_W;
    localparam int LOW  = afbr_pkg::LOG_OUT_W;
    localparam int LB   = afbr_pkg::LOG_BITS;

    localparam int LOG_OUT  = 4 + afbr_pkg::LOG_LAT;
    localparam int EXP_IN   = LOG_OUT + 4;
    localparam int EXP_OUT  = EXP_IN + afbr_pkg::EXP_LAT;
    localparam int DIV_OUT  = 3 + afbr_pkg::DIV_LAT;
    localparam int DIV_DLY  = EXP_OUT - DIV_OUT;
    localparam int META_DLY = EXP_OUT - 3;
    localparam int GSH_DLY  = afbr_pkg::EXP_LAT;

    // config registers
    logic [LW-1:0]                 r_target, r_band, r_width, r_show, r_met;
    logic [afbr_pkg::KAPPA_W-1:0]  r_kappa;
    logic [LW-1:0]                 r_alpha;
    logic                          r_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= LW'(afbr_pkg::ONE);
            r_band   <= '0;
            r_kappa  <= '0;
            r_width  <= LW'(afbr_pkg::ONE);
            r_alpha  <= LW'(2 * afbr_pkg::ONE);
            r_on     <= 1'b0;
            r_show   <= '0;
            r_met    <= LW'(afbr_pkg::ONE);
        end else if (i_cfg_wr_en) begin
            case (afbr_pkg::t_reg_idx'(i_cfg_index))
                afbr_pkg::REG_TARGET_DISTANCE: r_target <= i_cfg_wdata[LW-1:0];
                afbr_pkg::REG_BAND_HALFWIDTH:  r_band   <= i_cfg_wdata[LW-1:0];
                afbr_pkg::REG_SPRING_CONSTANT: r_kappa  <= i_cfg_wdata;
                afbr_pkg::REG_WELL_WIDTH:      r_width  <= i_cfg_wdata[LW-1:0];
                afbr_pkg::REG_SHAPE_EXPONENT:  r_alpha  <= i_cfg_wdata[LW-1:0];
                afbr_pkg::REG_RESTRAINT_ON:    r_on     <= i_cfg_wdata[0];
                afbr_pkg::REG_SHOW_LIMIT:      r_show   <= i_cfg_wdata[LW-1:0];
                afbr_pkg::REG_MET_LIMIT:       r_met    <= i_cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // clamped config
    logic [LW-1:0]  t_use, tol_use, c_use;
    logic [EAW:0]   e2;
    logic [EAW-1:0] ea;
    logic           e2neg;
    logic [LW:0]    alpha_x;
    logic [LW:0]    am;
    logic           is_harm, is_cauchy;

    assign t_use   = (r_target < LW'(afbr_pkg::MIN_TARGET)) ? LW'(afbr_pkg::MIN_TARGET)
                                                            : r_target;
    assign tol_use = (r_band > t_use) ? t_use : r_band;
    assign c_use   = (r_width < LW'(afbr_pkg::MIN_WIDTH)) ? LW'(afbr_pkg::MIN_WIDTH)
                                                          : r_width;
    assign e2      = {{(EAW + 1 - LW){r_alpha[LW-1]}}, r_alpha} - (EAW + 1)'(2 * afbr_pkg::ONE);
    assign e2neg   = e2[EAW];
    assign ea      = e2neg ? EAW'(-e2) : e2[EAW-1:0];
    assign alpha_x = {r_alpha[LW-1], r_alpha};
    assign am      = alpha_x[LW] ? -alpha_x : alpha_x;
    assign is_harm   = ea < EAW'(afbr_pkg::ALPHA_EPS);
    assign is_cauchy = am < (LW + 1)'(afbr_pkg::ALPHA_EPS);

    // config-derived products
    logic [afbr_pkg::C2_W-1:0] r_c2, r_metc, r_showc;
    logic [LW+EAW-1:0]         r_d_lo, r_d_hi;
    logic [afbr_pkg::D_W-1:0]  r_d;

    always_ff @(posedge i_clk) begin
        r_c2    <= c_use * c_use;
        r_metc  <= r_met * c_use;
        r_showc <= r_show * c_use;
        r_d_lo  <= r_c2[LW-1:0] * ea;
        r_d_hi  <= r_c2[2*LW-1:LW] * ea;
        r_d     <= (afbr_pkg::D_W'(r_d_hi) << LW) + afbr_pkg::D_W'(r_d_lo);
    end

    logic en;
    logic r_skid_valid;
    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // P1: input register
    logic          r_p1_valid, r_p1_sh;
    logic [LW-1:0] r_p1_r;

    // P2: offsets
    logic [LW:0]   dl, v;
    logic [LW-1:0] adl;
    logic          r_p2_valid, r_p2_active, r_p2_neg, r_p2_shp;
    logic [LW:0]   r_p2_v;

    assign dl  = {1'b0, r_p1_r} - {1'b0, t_use};
    assign adl = dl[LW] ? LW'(-dl) : dl[LW-1:0];
    assign v   = {1'b0, adl} - {1'b0, tol_use};

    // P3: products and flags
    logic [VMW-1:0]              vmag;
    logic                        met, trig;
    logic [afbr_pkg::KX_W-1:0]   r_p3_kx;
    logic [afbr_pkg::AX2_W-1:0]  r_p3_ax2;
    afbr_pkg::t_meta             r_p3_meta;

    assign vmag = {r_p2_v[LW-1:0], F'(0)};
    assign met  = r_p2_v[LW] || (CMPW'(vmag) < CMPW'(r_metc));
    assign trig = (r_show == '0) || (!r_p2_v[LW] && (CMPW'(vmag) >= CMPW'(r_showc)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid      <= 1'b0;
            r_p2_valid      <= 1'b0;
            r_p3_meta.valid <= 1'b0;
        end else if (en) begin
            r_p1_valid      <= i_in_valid;
            r_p2_valid      <= r_p1_valid;
            r_p3_meta.valid <= r_p2_valid;
        end
        if (en) begin
            r_p1_r             <= i_pair_distance;
            r_p1_sh            <= i_first_atom_shown & i_second_atom_shown;
            r_p2_v             <= v;
            r_p2_active        <= r_on & (|r_kappa) & !v[LW];
            r_p2_neg           <= dl[LW];
            r_p2_shp           <= r_p1_sh & r_on;
            r_p3_kx            <= r_kappa * r_p2_v[LW-1:0];
            r_p3_ax2           <= r_p2_v[LW-1:0] * r_p2_v[LW-1:0];
            r_p3_meta.active   <= r_p2_active;
            r_p3_meta.neg      <= r_p2_neg;
            r_p3_meta.azero    <= (r_p2_v[LW-1:0] == '0);
            r_p3_meta.met      <= met;
            r_p3_meta.shown    <= r_p2_shp & trig;
        end
    end

    // harmonic / Cauchy divider
    logic [afbr_pkg::NUM_W-1:0]   div_num;
    logic [afbr_pkg::DEN_W-1:0]   div_den;
    logic [FW-1:0]                div_q;

    assign div_num = is_harm ? (afbr_pkg::NUM_W'(r_p3_kx) << F)
                             : (afbr_pkg::NUM_W'({r_p3_kx, 1'b0}) << F);
    assign div_den = is_harm ? afbr_pkg::DEN_W'(r_c2)
                             : afbr_pkg::DEN_W'({r_c2, 1'b0}) + afbr_pkg::DEN_W'(r_p3_ax2);

    afbr_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quot (div_q)
    );

    // P4 and log2 units
    logic [afbr_pkg::KX_W-1:0]   r_p4_kx;
    logic [afbr_pkg::AX2_W-1:0]  r_p4_ax2;
    logic [afbr_pkg::LOG_W-1:0]  n_val;
    logic [LOW-1:0]              l_n, l_d, l_kx, l_c2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_kx  <= r_p3_kx;
            r_p4_ax2 <= r_p3_ax2;
        end
    end

    assign n_val = afbr_pkg::LOG_W'(r_d) + (afbr_pkg::LOG_W'(r_p4_ax2) << F);

    afbr_log2 u_log_n  (.i_clk(i_clk), .i_en(en), .i_value(n_val), .o_log(l_n));
    afbr_log2 u_log_d  (.i_clk(i_clk), .i_en(en), .i_value(afbr_pkg::LOG_W'(r_d)),
                        .o_log(l_d));
    afbr_log2 u_log_kx (.i_clk(i_clk), .i_en(en), .i_value(afbr_pkg::LOG_W'(r_p4_kx)),
                        .o_log(l_kx));
    afbr_log2 u_log_c2 (.i_clk(i_clk), .i_en(en), .i_value(afbr_pkg::LOG_W'(r_c2)),
                        .o_log(l_c2));

    // general shape exponent
    logic [LOW-1:0]                      r_g1_lu;
    logic [SW-1:0]                       r_g1_sk, r_g2_sk, r_g3_s;
    logic [LB+EAW-1:0]                   r_g2_plo;
    logic [LOW-LB+EAW-1:0]               r_g2_phi;
    logic [afbr_pkg::PROD_W-1:0]         prod;
    logic [SW-1:0]                       pm;
    logic [afbr_pkg::EXP_BITS-1:0]       r_g4_fr;
    afbr_pkg::t_gsh                      r_g4_sh;

    assign prod = (afbr_pkg::PROD_W'(r_g2_phi) << LB) + afbr_pkg::PROD_W'(r_g2_plo);
    assign pm   = SW'(prod >> (F + 1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g1_lu  <= (l_n > l_d) ? l_n - l_d : '0;
            r_g1_sk  <= SW'(l_kx) - SW'(l_c2) + (SW'(F) << LB);
            r_g2_plo <= r_g1_lu[LB-1:0] * ea;
            r_g2_phi <= r_g1_lu[LOW-1:LB] * ea;
            r_g2_sk  <= r_g1_sk;
            r_g3_s   <= e2neg ? r_g2_sk - pm : r_g2_sk + pm;
            r_g4_fr        <= r_g3_s[LB-1:0];
            r_g4_sh.zero   <= r_g3_s[SW-1];
            r_g4_sh.sat    <= !r_g3_s[SW-1] && (r_g3_s >= (SW'(FW - 1) << LB));
            r_g4_sh.ipart  <= r_g3_s[LB +: afbr_pkg::INT_W];
        end
    end

    logic [afbr_pkg::EXP_BITS-1:0] ex_m;

    afbr_exp2 u_exp (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_frac (r_g4_fr),
        .o_mant (ex_m)
    );

    // alignment
    afbr_pkg::t_meta r_meta_dly [META_DLY];
    logic [FW-1:0]   r_div_dly  [DIV_DLY];
    afbr_pkg::t_gsh  r_gsh_dly  [GSH_DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < META_DLY; k++) r_meta_dly[k] <= '0;
        end else if (en) begin
            r_meta_dly[0] <= r_p3_meta;
            for (int k = 1; k < META_DLY; k++) r_meta_dly[k] <= r_meta_dly[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div_dly[0] <= div_q;
            for (int k = 1; k < DIV_DLY; k++) r_div_dly[k] <= r_div_dly[k-1];
            r_gsh_dly[0] <= r_g4_sh;
            for (int k = 1; k < GSH_DLY; k++) r_gsh_dly[k] <= r_gsh_dly[k-1];
        end
    end

    // final select
    afbr_pkg::t_meta   last_meta;
    afbr_pkg::t_gsh    last_gsh;
    logic [FW-1:0]     gen_mag, gen_shl, mag;
    afbr_pkg::t_result last_res;

    assign last_meta = r_meta_dly[META_DLY-1];
    assign last_gsh  = r_gsh_dly[GSH_DLY-1];
    assign gen_shl   = FW'(ex_m) << (last_gsh.ipart - afbr_pkg::INT_W'(LB - 1));

    always_comb begin
        if (last_gsh.zero) begin
            gen_mag = '0;
        end else if (last_gsh.sat) begin
            gen_mag = afbr_pkg::FORCE_MAX;
        end else if (last_gsh.ipart >= afbr_pkg::INT_W'(LB - 1)) begin
            gen_mag = (gen_shl > afbr_pkg::FORCE_MAX) ? afbr_pkg::FORCE_MAX : gen_shl;
        end else begin
            gen_mag = FW'(ex_m) >> (afbr_pkg::INT_W'(LB - 1) - last_gsh.ipart);
        end
        if (!last_meta.active || last_meta.azero) begin
            mag = '0;
        end else if (is_harm || is_cauchy) begin
            mag = r_div_dly[DIV_DLY-1];
        end else begin
            mag = gen_mag;
        end
        last_res.force_value = last_meta.neg ? -mag : mag;
        last_res.is_met      = last_meta.met;
        last_res.is_shown    = last_meta.shown;
    end

    // output register and skid
    afbr_pkg::t_result r_out, r_skid;
    logic              r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en) begin
            if (last_meta.valid) begin
                if (r_out_valid && i_out_stall) begin
                    r_skid       <= last_res;
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out       <= last_res;
                    r_out_valid <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end else if (!i_out_stall) begin
            r_out        <= r_skid;
            r_skid_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_force_value = r_out.force_value;
    assign o_is_met      = r_out.is_met;
    assign o_is_shown    = r_out.is_shown;

endmodule

@@ hw/rtl/afbr_checker.sv @@
// ----------------------------------------------------------------------------
// afbr_checker
// Port-level checks for the restraint force core, bound to the top level.
// ----------------------------------------------------------------------------
module afbr_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic [afbr_pkg::LEN_W-1:0]            i_pair_distance,
    input logic                                  i_first_atom_shown,
    input logic                                  i_second_atom_shown,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [afbr_pkg::FORCE_W-1:0]   o_force_value,
    input logic                                  o_is_met,
    input logic                                  o_is_shown,
    input logic                                  i_cfg_wr_en,
    input logic [afbr_pkg::IDX_W-1:0]            i_cfg_index,
    input logic [afbr_pkg::CFG_W-1:0]            i_cfg_wdata
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or skid not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_force_value)
                                       && $stable(o_is_met) && $stable(o_is_shown))
        else $error("stalled result changed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall && o_out_valid)
        else $error("skid register did not drain on transfer");

endmodule

bind adaptive_flat_bottom_restraint_force_core afbr_checker u_afbr_checker (.*);
